/* design/msct_pkg.sv */
// Shared types and constants of the matrix-shaper color transform.
// Used by every module of the block; depends on nothing.
package msct_pkg;

  localparam int OUT_INDEX_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS     = 16;
  localparam int GAMMA_FRAC_BITS    = 16;

  localparam int NUM_CH     = 3;
  localparam int PIX_W      = 8;
  localparam int CH_W       = 2;
  localparam int IDX_W      = 16;
  localparam int GAMMA_W    = 17;
  localparam int GAMMA_DEPTH = 1 << PIX_W;
  localparam int COEF_W     = 18;
  localparam int ROW_W      = COEF_W * NUM_CH;
  localparam int CFG_IDX_W  = 2;

  // unsigned gamma times signed weight, and the sum of three of them
  localparam int PROD_W = GAMMA_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BLUE  = 2'd2;

  localparam logic [ROW_W-1:0] ROW_RED_RST   = 54'd65536;
  localparam logic [ROW_W-1:0] ROW_GREEN_RST = 54'd17179869184;
  localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 54'd4503599627370496;

  typedef enum logic [1:0] {
    REQ_PIXEL    = 2'd0,
    REQ_GAMMA_WR = 2'd1,
    REQ_OUT_WR   = 2'd2
  } req_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [GAMMA_W-1:0]       gamma_t;

  // request fields that travel alongside the datapath
  typedef struct packed {
    req_e              req;
    logic [CH_W-1:0]   channel;
    logic [IDX_W-1:0]  index;
    logic [GAMMA_W-1:0] value;
    logic [PIX_W-1:0]  alpha;
    logic              last;
  } side_t;

endpackage

/* design/msct_gamma.sv */
// Input stage: per-channel 256-entry gamma memories with registered read.
// Depends on msct_pkg.
module msct_gamma (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  msct_pkg::side_t                             side_i,
  input  logic [msct_pkg::NUM_CH-1:0][msct_pkg::PIX_W-1:0] pix_i,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output msct_pkg::side_t                             side_o,
  output msct_pkg::gamma_t [msct_pkg::NUM_CH-1:0]     gamma_o
);
  import msct_pkg::*;

  logic  valid_q;
  side_t side_q;
  logic  accept;
  logic  keep;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  // gamma writes finish here; only pixels and output-table writes go on
  assign keep    = (side_i.req == REQ_PIXEL) || (side_i.req == REQ_OUT_WR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      side_q <= side_i;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    gamma_t mem [GAMMA_DEPTH];
    gamma_t rd_q;

    always_ff @(posedge clk_i) begin
      if (accept && side_i.req == REQ_GAMMA_WR && side_i.channel == CH_W'(c)) begin
        mem[side_i.index[PIX_W-1:0]] <= side_i.value;
      end
      if (ready_o) begin
        rd_q <= mem[pix_i[c]];
      end
    end

    assign gamma_o[c] = rd_q;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;

endmodule

/* design/msct_mix.sv */
// Matrix mix: multiply stage, sum stage, then round and clamp to a table index.
// Depends on msct_pkg.
module msct_mix #(
  parameter int OUT_INDEX_BITS = msct_pkg::OUT_INDEX_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  msct_pkg::side_t                               side_i,
  input  msct_pkg::gamma_t [msct_pkg::NUM_CH-1:0]       gamma_i,
  // coef_i[in][out]: weight of input channel toward output channel
  input  msct_pkg::coef_t [msct_pkg::NUM_CH-1:0][msct_pkg::NUM_CH-1:0] coef_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output msct_pkg::side_t                               side_o,
  output logic [msct_pkg::NUM_CH-1:0][OUT_INDEX_BITS-1:0] index_o
);
  import msct_pkg::*;

  localparam int SHIFT = GAMMA_FRAC_BITS + COEF_FRAC_BITS - OUT_INDEX_BITS;
  localparam logic [SUM_W-1:0] RND      = SUM_W'(1) << (SHIFT - 1);
  localparam logic [SUM_W-1:0] IDX_MAX  = SUM_W'((1 << OUT_INDEX_BITS) - 1);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  function automatic prod_t mul(gamma_t g, coef_t c);
    logic signed [PROD_W:0] full;
    full = $signed({1'b0, g}) * c;
    return prod_t'(full[PROD_W-1:0]);
  endfunction

  logic  v2_q, v3_q, v4_q;
  logic  en2, en3, en4;
  side_t side2_q, side3_q, side4_q;
  prod_t prod_d [NUM_CH][NUM_CH];
  prod_t prod_q [NUM_CH][NUM_CH];
  sum_t  sum_d  [NUM_CH];
  sum_t  sum_q  [NUM_CH];
  logic [NUM_CH-1:0][OUT_INDEX_BITS-1:0] idx_d, idx_q;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      for (int j = 0; j < NUM_CH; j++) begin
        prod_d[k][j] = mul(gamma_i[j], coef_i[j][k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_d[k] = SUM_W'(prod_q[k][0]) + SUM_W'(prod_q[k][1]) + SUM_W'(prod_q[k][2]);
    end
  end

  always_comb begin
    logic [SUM_W-1:0] rounded;
    for (int k = 0; k < NUM_CH; k++) begin
      rounded = (SUM_W'(unsigned'(sum_q[k])) + RND) >> SHIFT;
      if (sum_q[k][SUM_W-1]) begin
        idx_d[k] = '0;
      end else if (rounded > IDX_MAX) begin
        idx_d[k] = '1;
      end else begin
        idx_d[k] = rounded[OUT_INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en2) v2_q <= valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      side2_q <= side_i;
      prod_q  <= prod_d;
    end
    if (en3) begin
      side3_q <= side2_q;
      sum_q   <= sum_d;
    end
    if (en4) begin
      side4_q <= side3_q;
      idx_q   <= idx_d;
    end
  end

  assign valid_o = v4_q;
  assign side_o  = side4_q;
  assign index_o = idx_q;

endmodule

/* design/msct_lut.sv */
// Output stage: per-channel 8-bit output table memories and the result register.
// Depends on msct_pkg.
module msct_lut #(
  parameter int OUT_INDEX_BITS = msct_pkg::OUT_INDEX_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            ready_o,
  input  msct_pkg::side_t                                 side_i,
  input  logic [msct_pkg::NUM_CH-1:0][OUT_INDEX_BITS-1:0] index_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [msct_pkg::NUM_CH-1:0][msct_pkg::PIX_W-1:0] pix_o,
  output logic [msct_pkg::PIX_W-1:0]                      alpha_o,
  output logic                                            last_o
);
  import msct_pkg::*;

  localparam int OUT_DEPTH = 1 << OUT_INDEX_BITS;

  logic             valid_q;
  logic [PIX_W-1:0] alpha_q;
  logic             last_q;
  logic             move;

  assign ready_o = !valid_q || out_ready_i;
  assign move    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && side_i.req == REQ_PIXEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      alpha_q <= side_i.alpha;
      last_q  <= side_i.last;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [PIX_W-1:0] mem [OUT_DEPTH];
    logic [PIX_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (move && side_i.req == REQ_OUT_WR && side_i.channel == CH_W'(c)) begin
        mem[side_i.index[OUT_INDEX_BITS-1:0]] <= side_i.value[PIX_W-1:0];
      end
      if (ready_o) begin
        rd_q <= mem[index_i[c]];
      end
    end

    assign pix_o[c] = rd_q;
  end

  assign out_valid_o = valid_q;
  assign alpha_o     = alpha_q;
  assign last_o      = last_q;

endmodule

/* design/matrix_shaper_color_transform_top.sv */
// Top level of the matrix-shaper color transform: config registers and the pipeline.
// Depends on msct_pkg, msct_gamma, msct_mix and msct_lut.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per cycle when ready:
//   a pixel, a gamma table write or an output table write, selected by req_type_i.
//   Pixels come out on the output channel (out_valid_o/out_ready_i) in order;
//   table writes and unknown request types give no result.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the three matrix rows by
//   index; it is always ready. Write rows only while the pipeline is empty.
//   A pixel passes gamma read, multiply, sum, round/clamp and output table read,
//   each a registered stage. Throughput: one request per cycle while the output
//   is not stalled; every stage holds a valid bit and fills bubbles. When the
//   receiver stalls, the result holds and stages behind it keep filling;
//   in_ready_o drops only once all five stages are full.
//   Reset clears the valid bits and restores identity matrix rows. Table
//   contents are undefined until written and get no clearing pass.
module matrix_shaper_color_transform_top #(
  parameter int OUT_INDEX_BITS = msct_pkg::OUT_INDEX_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       req_type_i,
  input  logic [msct_pkg::CH_W-1:0]        channel_i,
  input  logic [msct_pkg::IDX_W-1:0]       table_index_i,
  input  logic [msct_pkg::GAMMA_W-1:0]     table_value_i,
  input  logic [msct_pkg::PIX_W-1:0]       red_in_i,
  input  logic [msct_pkg::PIX_W-1:0]       green_in_i,
  input  logic [msct_pkg::PIX_W-1:0]       blue_in_i,
  input  logic [msct_pkg::PIX_W-1:0]       alpha_in_i,
  input  logic                             last_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [msct_pkg::PIX_W-1:0]       red_out_o,
  output logic [msct_pkg::PIX_W-1:0]       green_out_o,
  output logic [msct_pkg::PIX_W-1:0]       blue_out_o,
  output logic [msct_pkg::PIX_W-1:0]       alpha_out_o,
  output logic                             last_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [msct_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [msct_pkg::ROW_W-1:0]       cfg_data_i
);
  import msct_pkg::*;

  logic [ROW_W-1:0] row_red_q, row_green_q, row_blue_q;
  coef_t [NUM_CH-1:0][NUM_CH-1:0] coef;

  side_t side_in, side_g, side_m;
  logic [NUM_CH-1:0][PIX_W-1:0] pix_in, pix_out;
  gamma_t [NUM_CH-1:0] gamma;
  logic [NUM_CH-1:0][OUT_INDEX_BITS-1:0] index;
  logic valid_g, ready_g, valid_m, ready_m;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_red_q   <= ROW_RED_RST;
      row_green_q <= ROW_GREEN_RST;
      row_blue_q  <= ROW_BLUE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROW_RED:   row_red_q   <= cfg_data_i;
        REG_ROW_GREEN: row_green_q <= cfg_data_i;
        REG_ROW_BLUE:  row_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      coef[0][k] = coef_t'(row_red_q[COEF_W*k +: COEF_W]);
      coef[1][k] = coef_t'(row_green_q[COEF_W*k +: COEF_W]);
      coef[2][k] = coef_t'(row_blue_q[COEF_W*k +: COEF_W]);
    end
  end

  assign side_in.req     = req_e'(req_type_i);
  assign side_in.channel = channel_i;
  assign side_in.index   = table_index_i;
  assign side_in.value   = table_value_i;
  assign side_in.alpha   = alpha_in_i;
  assign side_in.last    = last_in_i;

  assign pix_in[0] = red_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = blue_in_i;

  msct_gamma u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .side_i  (side_in),
    .pix_i   (pix_in),
    .valid_o (valid_g),
    .ready_i (ready_g),
    .side_o  (side_g),
    .gamma_o (gamma)
  );

  msct_mix #(
    .OUT_INDEX_BITS (OUT_INDEX_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_g),
    .ready_o (ready_g),
    .side_i  (side_g),
    .gamma_i (gamma),
    .coef_i  (coef),
    .valid_o (valid_m),
    .ready_i (ready_m),
    .side_o  (side_m),
    .index_o (index)
  );

  msct_lut #(
    .OUT_INDEX_BITS (OUT_INDEX_BITS)
  ) u_lut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_m),
    .ready_o     (ready_m),
    .side_i      (side_m),
    .index_i     (index),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_o       (pix_out),
    .alpha_o     (alpha_out_o),
    .last_o      (last_out_o)
  );

  assign red_out_o   = pix_out[0];
  assign green_out_o = pix_out[1];
  assign blue_out_o  = pix_out[2];

endmodule

/* design/msct_checker.sv */
// Port-level checks for the color transform top level, attached by bind.
// Depends on msct_pkg and matrix_shaper_color_transform_top.
module msct_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [msct_pkg::PIX_W-1:0]       red_out_o,
  input logic [msct_pkg::PIX_W-1:0]       green_out_o,
  input logic [msct_pkg::PIX_W-1:0]       blue_out_o,
  input logic [msct_pkg::PIX_W-1:0]       alpha_out_o,
  input logic                             last_out_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o
);

  // no result survives reset
  a_reset_clear : assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // a stalled result holds with its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o)
      && $stable(alpha_out_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // the input side backs up only behind a blocked result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

  // config writes are never refused
  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind matrix_shaper_color_transform_top msct_checker u_msct_checker (.*);

/* test/matrix_shaper_color_transform_top_tb.sv */
// Testbench for the matrix-shaper color transform: random and directed requests
// checked against an in-bench predictor of the gamma, matrix mix and output lookup.
// Depends on msct_pkg and matrix_shaper_color_transform_top.
module matrix_shaper_color_transform_top_tb;
  import msct_pkg::*;

  localparam int OUT_BITS      = OUT_INDEX_BITS_DEF;
  localparam int OUT_DEPTH     = 1 << OUT_BITS;
  localparam int MIX_SHIFT     = GAMMA_FRAC_BITS + COEF_FRAC_BITS - OUT_BITS;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [1:0]           REQ_UNKNOWN = 2'd3;
  localparam logic [CH_W-1:0]      CH_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CH_W-1:0]    channel;
    logic [IDX_W-1:0]   index;
    logic [GAMMA_W-1:0] value;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   alpha;
    logic               last;
  } request_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             last;
  } pixel_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  request_t           in_req = '0;
  logic [1:0]         req_type_i;
  logic [CH_W-1:0]    channel_i;
  logic [IDX_W-1:0]   table_index_i;
  logic [GAMMA_W-1:0] table_value_i;
  logic [PIX_W-1:0]   red_in_i, green_in_i, blue_in_i, alpha_in_i;
  logic               last_in_i;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [PIX_W-1:0]   red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic               last_out_o;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ROW_W-1:0]     cfg_data_i  = '0;

  assign req_type_i    = in_req.kind;
  assign channel_i     = in_req.channel;
  assign table_index_i = in_req.index;
  assign table_value_i = in_req.value;
  assign red_in_i      = in_req.red;
  assign green_in_i    = in_req.green;
  assign blue_in_i     = in_req.blue;
  assign alpha_in_i    = in_req.alpha;
  assign last_in_i     = in_req.last;

  matrix_shaper_color_transform_top #(
    .OUT_INDEX_BITS(OUT_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .channel_i    (channel_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .last_out_o   (last_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor state, advanced on accepted requests and config writes
  gamma_t           gamma_lut [NUM_CH][GAMMA_DEPTH];
  logic [PIX_W-1:0] tone_lut [NUM_CH][OUT_DEPTH];
  logic [ROW_W-1:0] shaper_row [NUM_CH] = '{ROW_RED_RST, ROW_GREEN_RST, ROW_BLUE_RST};

  // stimulus-side view of what has been written, so no unwritten entry is read
  gamma_t           plan_gamma [NUM_CH][GAMMA_DEPTH];
  bit               plan_gamma_ok [NUM_CH][GAMMA_DEPTH];
  bit               plan_tone_ok [NUM_CH][OUT_DEPTH];
  logic [ROW_W-1:0] plan_row [NUM_CH] = '{ROW_RED_RST, ROW_GREEN_RST, ROW_BLUE_RST};

  request_t stream_requests [$];
  pixel_t   shaped_pixels [$];
  request_t next_req;
  pixel_t   oldest_pixel;
  int       idle_pct = 30;
  int       errors = 0;
  int       cycle_count = 0;

  function automatic logic [OUT_BITS-1:0] shaped_index(input gamma_t g0, g1, g2,
      input logic [ROW_W-1:0] r0, r1, r2, input int k);
    longint mix;
    mix = longint'(g0) * longint'(coef_t'(r0[COEF_W*k +: COEF_W]))
        + longint'(g1) * longint'(coef_t'(r1[COEF_W*k +: COEF_W]))
        + longint'(g2) * longint'(coef_t'(r2[COEF_W*k +: COEF_W]));
    if (mix < 0) return '0;
    mix = (mix + (longint'(1) << (MIX_SHIFT - 1))) >>> MIX_SHIFT;
    if (mix > longint'(OUT_DEPTH - 1)) return '1;
    return mix[OUT_BITS-1:0];
  endfunction

  task automatic apply_transform(input request_t q);
    gamma_t g0, g1, g2;
    pixel_t px;
    case (q.kind)
      REQ_GAMMA_WR: if (q.channel < NUM_CH) gamma_lut[q.channel][q.index[PIX_W-1:0]] = q.value;
      REQ_OUT_WR:   if (q.channel < NUM_CH) tone_lut[q.channel][q.index[OUT_BITS-1:0]] = q.value[7:0];
      REQ_PIXEL: begin
        g0 = gamma_lut[0][q.red];
        g1 = gamma_lut[1][q.green];
        g2 = gamma_lut[2][q.blue];
        px.red   = tone_lut[0][shaped_index(g0, g1, g2, shaper_row[0], shaper_row[1],
                                            shaper_row[2], 0)];
        px.green = tone_lut[1][shaped_index(g0, g1, g2, shaper_row[0], shaper_row[1],
                                            shaper_row[2], 1)];
        px.blue  = tone_lut[2][shaped_index(g0, g1, g2, shaper_row[0], shaper_row[1],
                                            shaper_row[2], 2)];
        px.alpha = q.alpha;
        px.last  = q.last;
        shaped_pixels.push_back(px);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  function automatic request_t random_request();
    request_t q;
    q.kind    = 2'($urandom_range(3));
    q.channel = CH_W'($urandom_range(3));
    q.index   = IDX_W'($urandom);
    q.value   = GAMMA_W'($urandom_range(65536));
    q.red     = PIX_W'($urandom);
    q.green   = PIX_W'($urandom);
    q.blue    = PIX_W'($urandom);
    q.alpha   = PIX_W'($urandom);
    q.last    = 1'($urandom);
    return q;
  endfunction

  // often one of seven recurring levels so output indexes repeat
  function automatic gamma_t pick_gamma();
    case ($urandom_range(15))
      0: return 17'h00000;
      1: return 17'h00001;
      2: return 17'h08000;
      3: return 17'h0FFFF;
      4: return 17'h10000;
      5: return 17'h04000;
      6: return 17'h0C000;
      default: return GAMMA_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[ROW_W-1:0];
  endfunction

  // weights within +-0.75 keep the mix mostly inside the output range
  function automatic logic [ROW_W-1:0] mild_row();
    logic [ROW_W-1:0] row;
    int w;
    for (int k = 0; k < NUM_CH; k++) begin
      w = int'($urandom_range(98304)) - 49152;
      row[COEF_W*k +: COEF_W] = COEF_W'(w);
    end
    return row;
  endfunction

  task automatic push_request(input request_t q);
    if (q.channel < NUM_CH) begin
      if (q.kind == REQ_GAMMA_WR) begin
        plan_gamma[q.channel][q.index[PIX_W-1:0]] = q.value;
        plan_gamma_ok[q.channel][q.index[PIX_W-1:0]] = 1'b1;
      end else if (q.kind == REQ_OUT_WR) begin
        plan_tone_ok[q.channel][q.index[OUT_BITS-1:0]] = 1'b1;
      end
    end
    stream_requests.push_back(q);
  endtask

  task automatic write_entry(input logic [1:0] kind, input logic [CH_W-1:0] ch,
      input logic [IDX_W-1:0] idx, input logic [GAMMA_W-1:0] val);
    request_t q;
    q = random_request();
    q.kind    = kind;
    q.channel = ch;
    q.index   = idx;
    q.value   = val;
    push_request(q);
  endtask

  // load any not-yet-written table entry the pixel will read before the pixel itself
  task automatic queue_pixel(input logic [7:0] r, g, b, a, input logic last);
    request_t q;
    logic [7:0] pix [NUM_CH];
    logic [OUT_BITS-1:0] idx;
    pix[0] = r;
    pix[1] = g;
    pix[2] = b;
    for (int k = 0; k < NUM_CH; k++)
      if (!plan_gamma_ok[k][pix[k]])
        write_entry(REQ_GAMMA_WR, CH_W'(k), {8'($urandom), pix[k]}, pick_gamma());
    for (int k = 0; k < NUM_CH; k++) begin
      idx = shaped_index(plan_gamma[0][r], plan_gamma[1][g], plan_gamma[2][b],
                         plan_row[0], plan_row[1], plan_row[2], k);
      if (!plan_tone_ok[k][idx])
        write_entry(REQ_OUT_WR, CH_W'(k), idx, GAMMA_W'($urandom_range(65536)));
    end
    q = random_request();
    q.kind  = REQ_PIXEL;
    q.red   = r;
    q.green = g;
    q.blue  = b;
    q.alpha = a;
    q.last  = last;
    push_request(q);
  endtask

  task automatic random_traffic(input int count);
    request_t q;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        q = random_request();
        q.kind = REQ_UNKNOWN;
        push_request(q);
      end else if (sel < 10) begin
        write_entry(sel[0] ? REQ_GAMMA_WR : REQ_OUT_WR, CH_NONE, IDX_W'($urandom),
                    GAMMA_W'($urandom_range(65536)));
      end else if (sel < 22) begin
        write_entry(REQ_GAMMA_WR, CH_W'($urandom_range(2)), IDX_W'($urandom), pick_gamma());
      end else if (sel < 35) begin
        write_entry(REQ_OUT_WR, CH_W'($urandom_range(2)), IDX_W'($urandom),
                    GAMMA_W'($urandom_range(65536)));
      end else begin
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    $urandom_range(7) == 0);
      end
    end
  endtask

  // wait for the pipeline to empty, including trailing table writes;
  // sample between edges so the driver's updates have landed
  task automatic settle();
    while (stream_requests.size() != 0 || in_valid_i || shaped_pixels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx < NUM_CH) plan_row[idx] = data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_rows(input logic [ROW_W-1:0] r0, r1, r2, input bit with_spare);
    settle();
    write_row(REG_ROW_RED, r0);
    write_row(REG_ROW_GREEN, r1);
    write_row(REG_ROW_BLUE, r2);
    if (with_spare) write_row(REG_NONE, random_row());
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) apply_transform(in_req);
      if (!in_valid_i || in_ready_o) begin
        if (stream_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = stream_requests.pop_front();
          in_req     <= next_req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW_RED:   shaper_row[0] <= cfg_data_i;
        REG_ROW_GREEN: shaper_row[1] <= cfg_data_i;
        REG_ROW_BLUE:  shaper_row[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shaped_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d a=%0d last=%0d",
                 $time, red_out_o, green_out_o, blue_out_o, alpha_out_o, last_out_o);
      end else begin
        oldest_pixel = shaped_pixels.pop_front();
        check_field("red", oldest_pixel.red, red_out_o);
        check_field("green", oldest_pixel.green, green_out_o);
        check_field("blue", oldest_pixel.blue, blue_out_o);
        check_field("alpha", oldest_pixel.alpha, alpha_out_o);
        check_field("last", {7'd0, oldest_pixel.last}, {7'd0, last_out_o});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity rows from reset: table extremes, ignored requests, clamp at full scale
    for (int k = 0; k < NUM_CH; k++) begin
      write_entry(REQ_GAMMA_WR, CH_W'(k), 16'hFF00, 17'h00000);
      write_entry(REQ_GAMMA_WR, CH_W'(k), 16'hABFF, 17'h10000);
      write_entry(REQ_OUT_WR, CH_W'(k), 16'h0000, 17'h10055 + k);
      write_entry(REQ_OUT_WR, CH_W'(k), 16'hFFFF, 17'h000FF - k);
    end
    write_entry(REQ_UNKNOWN, 2'd0, 16'h0000, 17'h00001);
    write_entry(REQ_GAMMA_WR, CH_NONE, 16'h0000, 17'h00005);
    write_entry(REQ_OUT_WR, CH_NONE, 16'h0000, 17'h00007);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'h5A, 1'b0);
    write_entry(REQ_GAMMA_WR, 2'd0, 16'h0000, 17'h08000);
    queue_pixel(8'd0, 8'd0, 8'd255, 8'hA5, 1'b1);
    random_traffic(50);

    load_rows('0, '0, '0, 1'b1);
    random_traffic(20);

    load_rows({3{18'h1FFFF}}, {3{18'h1FFFF}}, {3{18'h1FFFF}}, 1'b0);
    random_traffic(20);

    load_rows({3{18'h20000}}, {3{18'h20000}}, {3{18'h20000}}, 1'b0);
    random_traffic(20);

    // back-to-back stretch with neither side idling
    load_rows(random_row(), random_row(), random_row(), 1'b0);
    idle_pct = 0;
    random_traffic(55);
    settle();
    idle_pct = 30;

    load_rows(mild_row(), mild_row(), mild_row(), 1'b0);
    random_traffic(45);

    load_rows({3{18'h1FFFF}}, {3{18'h20000}}, mild_row(), 1'b0);
    random_traffic(20);

    load_rows(ROW_RED_RST, ROW_GREEN_RST, ROW_BLUE_RST, 1'b0);
    random_traffic(15);

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
